### rtl/selt_pkg.sv
// Package with command and status codes and the controller state type for the lock table.
package selt_pkg;

  typedef enum logic [1:0] {
    CMD_LOCK       = 2'd0,
    CMD_UNLOCK     = 2'd1,
    CMD_UNLOCK_ALL = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_WAIT     = 3'd1,
    ST_DEADLOCK = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_REACH_RD,
    S_REACH,
    S_PEEL_RD,
    S_PEEL,
    S_OUT
  } state_e;

endpackage

### rtl/shared_exclusive_lock_table.sv
// Top level of the shared/exclusive lock table with deadlock detection.
//
//   channel | signals                                          | direction
//   in      | in_valid_i, in_stall_o, command_i, transaction_i,|
//           | resource_i, exclusive_i                          | into block
//   out     | out_valid_o, out_stall_i, status_o               | out of block
//
// One command at a time. Every command scans all LOCK_SLOTS slots, one per cycle,
// through the slot memory read port. A conflicting lock adds the graph search: a
// reach phase of up to TX_COUNT passes and a peel phase of up to TX_COUNT + 1
// passes, each pass reading every waits-for row in turn.
// Slot valid bits and waits-for row valid bits are flip-flops cleared by reset.
// The result waits in an output register; the next command is taken meanwhile
// only once the previous result has been moved out.
module shared_exclusive_lock_table #(
  parameter int TX_COUNT   = 16,
  parameter int LOCK_SLOTS = 64,
  parameter int RES_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  transaction_i,
  input  logic [15:0] resource_i,
  input  logic        exclusive_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o
);

  localparam int TxW   = $clog2(TX_COUNT);
  localparam int SlotW = $clog2(LOCK_SLOTS);
  localparam int EntW  = TxW + RES_BITS + 1;

  selt_pkg::state_e state_q, state_d;

  // Latched command.
  logic [1:0]          cmd_q;
  logic [TxW-1:0]      tx_q;
  logic [RES_BITS-1:0] res_q;
  logic                excl_q;

  logic [LOCK_SLOTS-1:0] valid_q, valid_d;
  logic [TX_COUNT-1:0]   rowv_q, rowv_d;
  logic [SlotW:0]        cnt_q, cnt_d;        // slot scan read address
  logic [SlotW-1:0]      chk_q, chk_d;        // slot whose data is on rdata
  logic [TX_COUNT-1:0]   holders_q, holders_d;
  logic                  free_ok_q, free_ok_d;
  logic [SlotW-1:0]      free_q, free_d;
  logic [TX_COUNT-1:0]   reach_q, reach_d, next_q, next_d;
  logic                  chg_q, chg_d;
  logic [TxW:0]          v_q, v_d;
  logic [TxW-1:0]        vr_q, vr_d;
  logic [2:0]            status_q, status_d;
  logic                  ovalid_q, ovalid_d;

  // Memory ports.
  logic             sm_we;
  logic [SlotW-1:0] sm_waddr, sm_raddr;
  logic [EntW-1:0]  sm_wdata, sm_rdata;
  logic             wf_we;
  logic [TxW-1:0]   wf_waddr, wf_raddr;
  logic [TX_COUNT-1:0] wf_wdata, wf_rdata, wf_row;

  selt_slot_mem #(.Depth(LOCK_SLOTS), .Width(EntW)) u_slots (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );

  selt_wf_mem #(.Depth(TX_COUNT)) u_wf (
    .clk_i, .we_i(wf_we), .waddr_i(wf_waddr), .wdata_i(wf_wdata),
    .raddr_i(wf_raddr), .rdata_o(wf_rdata)
  );

  // A row never written since reset or since clearing reads as zero.
  assign wf_row = rowv_q[vr_q] ? wf_rdata : '0;

  logic [TxW-1:0]      ent_tx;
  logic [RES_BITS-1:0] ent_res;
  logic                ent_excl;
  assign {ent_tx, ent_res, ent_excl} = sm_rdata;

  // The transaction number is folded into the range of the table.
  logic [TxW-1:0] tx_in;
  always_comb begin
    tx_in = '0;
    for (int k = 0; k < 16; k++) begin
      if (transaction_i == 4'(k)) begin
        tx_in = TxW'(k % TX_COUNT);
      end
    end
  end

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != selt_pkg::S_IDLE) || ovalid_q;
  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    rowv_d    = rowv_q;
    cnt_d     = cnt_q;
    chk_d     = chk_q;
    holders_d = holders_q;
    free_ok_d = free_ok_q;
    free_d    = free_q;
    reach_d   = reach_q;
    next_d    = next_q;
    chg_d     = chg_q;
    v_d       = v_q;
    vr_d      = vr_q;
    status_d  = status_q;
    ovalid_d  = ovalid_q;
    sm_we     = 1'b0;
    sm_waddr  = free_q;
    sm_wdata  = {tx_q, res_q, excl_q};
    sm_raddr  = cnt_q[SlotW-1:0];
    wf_we     = 1'b0;
    wf_waddr  = tx_q;
    wf_wdata  = '0;
    wf_raddr  = v_q[TxW-1:0];
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      selt_pkg::S_IDLE: begin
        if (accept) begin
          cnt_d     = '0;
          holders_d = '0;
          free_ok_d = 1'b0;
          state_d   = selt_pkg::S_SCAN;
        end
      end
      selt_pkg::S_SCAN, selt_pkg::S_SCAN_LAST: begin
        // Data of slot chk_q is on the read port, except in the first cycle.
        if (cnt_q != '0) begin
          if (!valid_q[chk_q]) begin
            if (!free_ok_q) begin
              free_ok_d = 1'b1;
              free_d    = chk_q;
            end
          end else if (ent_tx == tx_q) begin
            if (cmd_q == selt_pkg::CMD_UNLOCK_ALL ||
                (cmd_q == selt_pkg::CMD_UNLOCK && ent_res == res_q)) begin
              valid_d[chk_q] = 1'b0;
            end
          end else if (ent_res == res_q && (excl_q || ent_excl)) begin
            holders_d[ent_tx] = 1'b1;
          end
        end
        chk_d = cnt_q[SlotW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (state_q == selt_pkg::S_SCAN_LAST) begin
          state_d = selt_pkg::S_DECIDE;
        end else if (cnt_q == (SlotW+1)'(LOCK_SLOTS - 1)) begin
          state_d = selt_pkg::S_SCAN_LAST;
        end
      end
      selt_pkg::S_DECIDE: begin
        state_d = selt_pkg::S_OUT;
        status_d = selt_pkg::ST_RELEASED;
        if (cmd_q == selt_pkg::CMD_UNLOCK_ALL) begin
          rowv_d[tx_q] = 1'b0;
        end else if (cmd_q == selt_pkg::CMD_LOCK) begin
          if (holders_q == '0) begin
            if (free_ok_q) begin
              sm_we          = 1'b1;
              valid_d[free_q] = 1'b1;
              rowv_d[tx_q]   = 1'b0;
              status_d       = selt_pkg::ST_GRANTED;
            end else begin
              status_d = selt_pkg::ST_FULL;
            end
          end else begin
            wf_we        = 1'b1;
            wf_wdata     = holders_q;
            rowv_d[tx_q] = 1'b1;
            reach_d      = '0;
            reach_d[tx_q] = 1'b1;
            next_d       = reach_d;
            v_d          = '0;
            state_d      = selt_pkg::S_REACH_RD;
          end
        end
      end
      selt_pkg::S_REACH_RD: begin
        // Issue the read of row v; data arrives next cycle.
        vr_d    = v_q[TxW-1:0];
        v_d     = v_q + 1'b1;
        state_d = selt_pkg::S_REACH;
      end
      selt_pkg::S_REACH: begin
        if (reach_q[vr_q]) begin
          next_d = next_q | wf_row;
        end
        if (v_q == (TxW+1)'(TX_COUNT)) begin
          v_d = '0;
          if ((next_d != reach_q)) begin
            reach_d = next_d;
            state_d = selt_pkg::S_REACH_RD;
          end else begin
            chg_d   = 1'b0;
            state_d = selt_pkg::S_PEEL_RD;
          end
        end else begin
          vr_d = v_q[TxW-1:0];
          v_d  = v_q + 1'b1;
        end
      end
      selt_pkg::S_PEEL_RD: begin
        vr_d    = v_q[TxW-1:0];
        v_d     = v_q + 1'b1;
        state_d = selt_pkg::S_PEEL;
      end
      selt_pkg::S_PEEL: begin
        // Sequential peel matches the in-place update order.
        if (reach_q[vr_q] && ((wf_row & reach_q) == '0)) begin
          reach_d[vr_q] = 1'b0;
          chg_d = 1'b1;
        end
        if (v_q == (TxW+1)'(TX_COUNT)) begin
          v_d = '0;
          if (chg_d) begin
            chg_d   = 1'b0;
            state_d = selt_pkg::S_PEEL_RD;
          end else if (reach_d != '0) begin
            rowv_d[tx_q] = 1'b0;
            status_d     = selt_pkg::ST_DEADLOCK;
            state_d      = selt_pkg::S_OUT;
          end else begin
            status_d = selt_pkg::ST_WAIT;
            state_d  = selt_pkg::S_OUT;
          end
        end else begin
          vr_d = v_q[TxW-1:0];
          v_d  = v_q + 1'b1;
        end
      end
      selt_pkg::S_OUT: begin
        ovalid_d = 1'b1;
        state_d  = selt_pkg::S_IDLE;
      end
      default: state_d = selt_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= selt_pkg::S_IDLE;
      valid_q  <= '0;
      rowv_q   <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      v_q      <= '0;
      chg_q    <= 1'b0;
      free_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      rowv_q   <= rowv_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      v_q      <= v_d;
      chg_q    <= chg_d;
      free_ok_q <= free_ok_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      tx_q   <= tx_in;
      res_q  <= RES_BITS'(resource_i);
      excl_q <= exclusive_i;
    end
    chk_q     <= chk_d;
    holders_q <= holders_d;
    free_q    <= free_d;
    reach_q   <= reach_d;
    next_q    <= next_d;
    vr_q      <= vr_d;
    status_q  <= status_d;
  end

  // A new command is never taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> in_stall_o)
    else $error("input taken while result pending");

  // A result appears only after the output stage of the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == selt_pkg::S_OUT))
    else $error("result without sequencer output step");

  // A grant always fills a slot that was free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_we |-> !valid_q[free_q])
    else $error("grant overwrote a valid slot");

endmodule

### rtl/selt_slot_mem.sv
// Lock slot memory: one write port, one registered read port.
module selt_slot_mem #(
  parameter int Depth = 64,
  parameter int Width = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/selt_wf_mem.sv
// Waits-for row memory: one write port, one registered read port.
module selt_wf_mem #(
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Depth-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Depth-1:0]         rdata_o
);

  logic [Depth-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
